@@ design/assert_macros.svh @@
// Concurrent assertion helpers, clocked on clk_i and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_NEVER(label, prop, msg) \
  `ASSERT_CLK(label, !(prop), msg)

`endif

@@ design/oaie_pkg.sv @@
`default_nettype none

package oaie_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_APPEND = 3'd0,
    FUNC_DROP   = 3'd1,
    FUNC_INSERT = 3'd2,
    FUNC_ERASE  = 3'd3,
    FUNC_READ   = 3'd4
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic write;
    logic up;
    logic down;
    logic read;
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ design/oaie_cell.sv @@
`default_nettype none

module oaie_cell #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned AW         = 4,
  parameter int unsigned SLOT       = 0
) (
  input  wire logic                 clk_i,
  input  wire oaie_pkg::cell_cmd_t  cmd_i,
  input  wire logic [AW-1:0]        pos_i,
  input  wire logic [ELEM_WIDTH-1:0] value_i,
  input  wire logic [ELEM_WIDTH-1:0] left_i,
  input  wire logic [ELEM_WIDTH-1:0] right_i,
  output logic      [ELEM_WIDTH-1:0] data_o
);

  import oaie_pkg::*;

  localparam logic [AW-1:0] SLOT_P = AW'(SLOT);

  logic [ELEM_WIDTH-1:0] data_q;
  logic [ELEM_WIDTH-1:0] data_d;
  logic                  at_pos;
  logic                  above;

  assign at_pos = (pos_i == SLOT_P);
  assign above  = (SLOT_P > pos_i);

  always_comb begin
    priority if (cmd_i.write && at_pos) begin
      data_d = value_i;
    end else if (cmd_i.up && above) begin
      data_d = left_i;
    end else if (cmd_i.down && (above || at_pos)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

@@ design/oaie_ctrl.sv @@
`default_nettype none
`include "assert_macros.svh"

module oaie_ctrl #(
  parameter int unsigned CAPACITY = 16,
  localparam int unsigned CW = $clog2(CAPACITY + 1),
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire logic [oaie_pkg::FUNC_W-1:0]   func_i,
  input  wire logic [oaie_pkg::INDEX_W-1:0]  index_i,
  output oaie_pkg::cell_cmd_t                cmd_o,
  output logic      [AW-1:0]                 pos_o,
  output logic      [CW-1:0]                 count_next_o,
  output oaie_pkg::status_e                  status_o
);

  import oaie_pkg::*;

  localparam int unsigned   CMPW     = (CW > INDEX_W) ? CW : INDEX_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);

  logic [CW-1:0]   count_q;
  logic [CW-1:0]   count_d;
  logic [CMPW-1:0] idx_x;
  logic [CMPW-1:0] cnt_x;
  logic            full;
  cell_cmd_t       cmd;
  status_e         status;

  assign idx_x = CMPW'(index_i);
  assign cnt_x = CMPW'(count_q);
  assign full  = (count_q == FULL_CNT);

  always_comb begin
    cmd     = '0;
    pos_o   = '0;
    count_d = count_q;
    status  = ST_OK;
    unique case (func_e'(func_i))
      FUNC_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.write = 1'b1;
          pos_o     = AW'(count_q);
          count_d   = count_q + 1'b1;
        end
      end
      FUNC_DROP: begin
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end
      end
      FUNC_INSERT: begin
        if (idx_x > cnt_x) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd.write = 1'b1;
          cmd.up    = 1'b1;
          pos_o     = AW'(index_i);
          count_d   = count_q + 1'b1;
        end
      end
      FUNC_ERASE: begin
        if (idx_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          cmd.down = 1'b1;
          pos_o    = AW'(index_i);
          count_d  = count_q - 1'b1;
        end
      end
      FUNC_READ: begin
        if (idx_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          cmd.read = 1'b1;
          pos_o    = AW'(index_i);
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_o        = accept_i ? cmd : '0;
  assign count_next_o = count_d;
  assign status_o     = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= FULL_CNT, "count above capacity")
  `ASSERT_NEVER(a_shift_both, cmd_o.up && cmd_o.down, "shift up and down together")
  `ASSERT_CLK(a_write_grows, cmd_o.write |=> count_q == $past(count_q) + 1'b1, "write without growth")

endmodule

`default_nettype wire

@@ design/ordered_array_insert_erase.sv @@
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o  func_i, index_i, value_i
// out      source     out_valid_o / out_stall_i read_value_o, status_o, count_o, is_empty_o
//
// One item per cycle while in_stall_o is low; its result appears in the cycle after acceptance.
// The cells at and above the position shift in parallel on acceptance, so insert and erase cost the same as append.
// The next item sees the state left by the previous one with no gap.
// Reset clears the count and the output valid flag; cell contents and output data registers stay undefined.
// A held result stalls the input only while out_stall_i is high.
`default_nettype none
`include "assert_macros.svh"

module ordered_array_insert_erase #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic        [oaie_pkg::FUNC_W-1:0]   func_i,
  input  wire logic        [oaie_pkg::INDEX_W-1:0]  index_i,
  input  wire logic signed [oaie_pkg::VALUE_W-1:0]  value_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed      [oaie_pkg::VALUE_W-1:0]  read_value_o,
  output logic             [oaie_pkg::STATUS_W-1:0] status_o,
  output logic             [oaie_pkg::COUNT_W-1:0]  count_o,
  output logic                                      is_empty_o
);

  import oaie_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);

  logic                  accept;
  cell_cmd_t             cmd;
  logic [AW-1:0]         pos;
  logic [CW-1:0]         count_next;
  status_e               status;
  logic [ELEM_WIDTH-1:0] elem_in;
  logic [ELEM_WIDTH-1:0] data   [CAPACITY];
  logic [ELEM_WIDTH-1:0] elem_sel;
  logic [VALUE_W-1:0]    rd_ext;

  logic                  out_valid_q;
  logic [VALUE_W-1:0]    read_value_q;
  status_e               status_q;
  logic [COUNT_W-1:0]    count_q;
  logic                  empty_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign elem_in    = ELEM_WIDTH'($unsigned(value_i));

  oaie_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .func_i      (func_i),
    .index_i     (index_i),
    .cmd_o       (cmd),
    .pos_o       (pos),
    .count_next_o(count_next),
    .status_o    (status)
  );

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ELEM_WIDTH-1:0] left;
    logic [ELEM_WIDTH-1:0] right;
    if (k == 0) begin : g_first
      assign left = data[k];
    end else begin : g_mid_l
      assign left = data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right = data[k];
    end else begin : g_mid_r
      assign right = data[k+1];
    end
    oaie_cell #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .AW        (AW),
      .SLOT      (k)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .pos_i  (pos),
      .value_i(elem_in),
      .left_i (left),
      .right_i(right),
      .data_o (data[k])
    );
  end

  always_comb begin
    elem_sel = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (pos == AW'(k)) begin
        elem_sel = data[k];
      end
    end
  end

  if (ELEM_WIDTH >= VALUE_W) begin : g_wide
    assign rd_ext = elem_sel[VALUE_W-1:0];
  end else begin : g_narrow
    assign rd_ext = {{(VALUE_W - ELEM_WIDTH){elem_sel[ELEM_WIDTH-1]}}, elem_sel};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= cmd.read ? rd_ext : '0;
      status_q     <= status;
      count_q      <= COUNT_W'(count_next);
      empty_q      <= (count_next == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign count_o      = count_q;
  assign is_empty_o   = empty_q;

  `ASSERT_CLK(a_out_after_accept, accept |=> out_valid_o, "accepted item left no result")
  `ASSERT_CLK(a_err_reads_zero, out_valid_o && status_o != ST_OK |-> read_value_o == '0, "nonzero read on error")

endmodule

`default_nettype wire

@@ dv/ordered_array_insert_erase_test.sv @@
`timescale 1ns / 100ps

module ordered_array_insert_erase_test;
  import oaie_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned PHASES = 4;
  localparam int unsigned RANDOM_PER_PHASE = 120;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
  } array_op_t;

  typedef struct {
    logic signed [VALUE_W-1:0] read_value;
    status_e                   status;
    logic [COUNT_W-1:0]        count;
    logic                      is_empty;
  } array_reply_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [FUNC_W-1:0]           func_i = FUNC_APPEND;
  logic [INDEX_W-1:0]          index_i = '0;
  logic signed [VALUE_W-1:0]   value_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic signed [VALUE_W-1:0]   read_value_o;
  logic [STATUS_W-1:0]         status_o;
  logic [COUNT_W-1:0]          count_o;
  logic                        is_empty_o;

  int unsigned send_idle_by_phase [PHASES] = '{0, 62, 0, 9};
  int unsigned recv_stall_by_phase [PHASES] = '{0, 0, 62, 9};
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  array_op_t    pending_ops [$];
  array_reply_t expected_replies [$];
  array_op_t    drive_op;
  array_reply_t want_reply;
  int unsigned  err_count = 0;

  logic signed [VALUE_W-1:0] shadow_mem [CAPACITY];
  int unsigned shadow_n = 0;
  int unsigned plan_n = 0;

  ordered_array_insert_erase #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_value_o(read_value_o),
    .status_o    (status_o),
    .count_o     (count_o),
    .is_empty_o  (is_empty_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic array_reply_t apply_array_op(array_op_t op);
    array_reply_t r;
    r.read_value = '0;
    r.status = ST_OK;
    case (op.func)
      FUNC_APPEND: begin
        if (shadow_n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_mem[shadow_n] = op.value;
          shadow_n++;
        end
      end
      FUNC_DROP: begin
        if (shadow_n > 0) shadow_n--;
      end
      FUNC_INSERT: begin
        if (op.index > shadow_n) begin
          r.status = ST_RANGE;
        end else if (shadow_n >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = shadow_n; k > op.index; k--) shadow_mem[k] = shadow_mem[k-1];
          shadow_mem[op.index] = op.value;
          shadow_n++;
        end
      end
      FUNC_ERASE: begin
        if (op.index >= shadow_n) begin
          r.status = ST_RANGE;
        end else begin
          for (int k = op.index; k + 1 < shadow_n; k++) shadow_mem[k] = shadow_mem[k+1];
          shadow_n--;
        end
      end
      FUNC_READ: begin
        if (op.index >= shadow_n) r.status = ST_RANGE;
        else r.read_value = shadow_mem[op.index];
      end
      default: begin
      end
    endcase
    r.count = shadow_n[COUNT_W-1:0];
    r.is_empty = (shadow_n == 0);
    return r;
  endfunction

  task automatic queue_op(logic [FUNC_W-1:0] f, int unsigned idx,
                          logic signed [VALUE_W-1:0] val);
    array_op_t op;
    op = '{func: f, index: INDEX_W'(idx), value: val};
    pending_ops = {pending_ops, op};
    case (f)
      FUNC_APPEND: if (plan_n < CAPACITY) plan_n++;
      FUNC_DROP:   if (plan_n > 0) plan_n--;
      FUNC_INSERT: if (idx <= plan_n && plan_n < CAPACITY) plan_n++;
      FUNC_ERASE:  if (idx < plan_n) plan_n--;
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(7, 0))
      0: return VALUE_MIN;
      1: return VALUE_MAX;
      2: return '1;
      3: return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random_op();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 20) begin
      queue_op(FUNC_APPEND, $urandom_range(CAPACITY, 0), pick_value());
    end else if (r < 30) begin
      queue_op(FUNC_DROP, $urandom_range(CAPACITY, 0), $urandom);
    end else if (r < 45) begin
      if (plan_n < CAPACITY && $urandom_range(7, 0) == 0)
        queue_op(FUNC_INSERT, $urandom_range(CAPACITY, plan_n + 1), pick_value());
      else
        queue_op(FUNC_INSERT, $urandom_range(plan_n, 0), pick_value());
    end else if (r < 60) begin
      if (plan_n > 0) queue_op(FUNC_ERASE, $urandom_range(plan_n - 1, 0), $urandom);
      else queue_op(FUNC_ERASE, $urandom_range(CAPACITY, 0), $urandom);
    end else if (r < 88) begin
      if (plan_n > 0) queue_op(FUNC_READ, $urandom_range(plan_n - 1, 0), $urandom);
      else queue_op(FUNC_READ, $urandom_range(CAPACITY, 0), $urandom);
    end else if (r < 96) begin
      queue_op($urandom_range(1, 0) ? FUNC_READ : FUNC_ERASE,
               $urandom_range(CAPACITY, plan_n), $urandom);
    end else begin
      queue_op(FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)),
               $urandom_range(CAPACITY, 0), $urandom);
    end
  endtask

  task automatic check_field(string label, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, label, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      func_i <= FUNC_APPEND;
      index_i <= '0;
      value_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_replies = {expected_replies,
                            apply_array_op('{func: func_i, index: index_i, value: value_i})};
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          drive_op = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          func_i <= drive_op.func;
          index_i <= drive_op.index;
          value_i <= drive_op.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $display("%0t mismatch: expected no item, actual value %0h status %0d count %0d",
                   $time, read_value_o, status_o, count_o);
          err_count++;
        end else begin
          want_reply = expected_replies.pop_front();
          check_field("read_value", want_reply.read_value, read_value_o);
          check_field("status", 32'(want_reply.status), 32'(status_o));
          check_field("count", 32'(want_reply.count), 32'(count_o));
          check_field("is_empty", 32'(want_reply.is_empty), 32'(is_empty_o));
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      @(negedge clk_i);
      send_idle_pct = send_idle_by_phase[ph];
      recv_stall_pct = recv_stall_by_phase[ph];
      if (ph == 0) begin
        queue_op(FUNC_READ, 0, '0);
        queue_op(FUNC_ERASE, 0, '1);
        queue_op(FUNC_DROP, CAPACITY, '0);
        queue_op(FUNC_INSERT, 1, pick_value());
        queue_op(FUNC_INSERT, 0, VALUE_MIN);
        queue_op(FUNC_APPEND, CAPACITY - 1, VALUE_MAX);
        queue_op(FUNC_APPEND, 0, '1);
        queue_op(FUNC_INSERT, 3, '0);
        queue_op(FUNC_INSERT, 1, pick_value());
        queue_op(FUNC_READ, 0, '1);
        queue_op(FUNC_READ, 4, '0);
        queue_op(FUNC_READ, 5, '0);
        queue_op(FUNC_ERASE, 0, '0);
        queue_op(FUNC_ERASE, 3, '0);
        queue_op(FUNC_READ, 2, '0);
        for (int f = int'(FUNC_SPARE_LO); f <= int'(FUNC_SPARE_HI); f++)
          queue_op(FUNC_W'(f), $urandom_range(CAPACITY, 0), $urandom);
      end
      if (ph % 2 == 0) begin
        while (plan_n < CAPACITY) begin
          if ($urandom_range(1, 0)) queue_op(FUNC_INSERT, $urandom_range(plan_n, 0), pick_value());
          else queue_op(FUNC_APPEND, $urandom_range(CAPACITY, 0), pick_value());
        end
        queue_op(FUNC_APPEND, 0, pick_value());
        queue_op(FUNC_INSERT, CAPACITY, pick_value());
        queue_op(FUNC_INSERT, 0, pick_value());
        queue_op(FUNC_READ, CAPACITY, $urandom);
        queue_op(FUNC_ERASE, CAPACITY, $urandom);
        queue_op(FUNC_READ, CAPACITY - 1, $urandom);
      end else begin
        while (plan_n > 0) begin
          if ($urandom_range(1, 0)) queue_op(FUNC_DROP, $urandom_range(CAPACITY, 0), $urandom);
          else queue_op(FUNC_ERASE, $urandom_range(plan_n - 1, 0), $urandom);
        end
        queue_op(FUNC_DROP, 0, $urandom);
        queue_op(FUNC_READ, 0, $urandom);
        queue_op(FUNC_ERASE, 0, $urandom);
        queue_op(FUNC_INSERT, 1, pick_value());
      end
      repeat (RANDOM_PER_PHASE) queue_random_op();
      while (pending_ops.size() != 0 || in_valid_i || expected_replies.size() != 0)
        @(negedge clk_i);
    end
    repeat (8) @(negedge clk_i);
    if (err_count == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
